// ----- rtl/core/cwp_pkg.sv -----
// cwp_pkg: shared types, constants and helpers for circle_wall_pushout
// no dependencies
`timescale 1ns / 1ps
package cwp_pkg;

  localparam int MAX_WALLS = 256;
  localparam int ADDR_W    = $clog2(MAX_WALLS);
  localparam int CNT_W     = $clog2(MAX_WALLS + 1);
  localparam int Q_W       = 32;
  localparam int R_W       = 31;
  localparam int STORED_W  = 9;
  localparam int DIST_EPS  = 7;
  localparam int WIDE_W    = 64;
  localparam int ROOT_W    = 32;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_RESOLVE = 2'd1,
    KIND_REMOVE  = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD, S_RD, S_CLAMP, S_MDX, S_MDZ, S_MRR, S_CMP, S_SQS, S_SQW,
    S_MPX, S_DXS, S_DXW, S_MPZ, S_DZS, S_DZW, S_FACE, S_NEXT, S_RMW, S_OUT
  } state_t;

  // one table row, lo_x in the lowest bits
  typedef struct packed {
    logic        [Q_W-1:0] owner;
    logic signed [Q_W-1:0] hi_z;
    logic signed [Q_W-1:0] hi_x;
    logic signed [Q_W-1:0] lo_z;
    logic signed [Q_W-1:0] lo_x;
  } wall_t;

  localparam int ENTRY_W = $bits(wall_t);

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) sat32 = hi[Q_W-1:0];
    else if (v < lo) sat32 = lo[Q_W-1:0];
    else sat32 = v[Q_W-1:0];
  endfunction

endpackage

// ----- rtl/core/cwp_ram.sv -----
// cwp_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
module cwp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/cwp_sqrt.sv -----
// cwp_sqrt: iterative integer square root, one result bit per cycle
// depends on cwp_pkg
`timescale 1ns / 1ps
module cwp_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cwp_pkg::WIDE_W-1:0]   radicand,
  output logic                         done,
  output logic [cwp_pkg::ROOT_W-1:0]   root
);
  import cwp_pkg::*;

  localparam int CW = $clog2(ROOT_W);

  logic [WIDE_W-1:0] v_r, res_r, bit_r, sum;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;

  assign sum = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(ROOT_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(ROOT_W - 1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      res_r <= '0;
      bit_r <= WIDE_W'(1) << (WIDE_W - 2);
    end else if (busy_r) begin
      if (v_r >= sum) begin
        v_r   <= v_r - sum;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

// ----- rtl/core/cwp_div.sv -----
// cwp_div: restoring unsigned divider, one quotient bit per cycle
// depends on cwp_pkg
`timescale 1ns / 1ps
module cwp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cwp_pkg::WIDE_W-1:0]  dividend,
  input  logic [cwp_pkg::ROOT_W-1:0]  divisor,
  output logic                        done,
  output logic [cwp_pkg::WIDE_W-1:0]  quotient
);
  import cwp_pkg::*;

  localparam int CW = $clog2(WIDE_W);

  logic [ROOT_W:0]   rem_r, rem_sh;
  logic [WIDE_W-1:0] quo_r;
  logic [ROOT_W-1:0] dvs_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r, ge;

  assign rem_sh = {rem_r[ROOT_W-1:0], quo_r[WIDE_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(WIDE_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(WIDE_W - 1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quo_r <= {quo_r[WIDE_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/core/circle_wall_pushout.sv -----
// circle_wall_pushout: top level, wall table sequencer and push-out datapath
// depends on cwp_pkg, cwp_ram, cwp_sqrt, cwp_div
`timescale 1ns / 1ps
// walls live in one 160-bit wide ram of 256 rows (bounds and owner); one item is
// handled at a time and every item returns exactly one result. an add writes its
// row in the add state. remove and clear take a ram read step and a write-back
// step per stored wall. a resolve reads the walls in order; a wall out of reach
// on either axis passes through the read, clamp and next states only. a wall
// within reach on both axes adds the squared distance test, then the square root
// when the circle overlaps, then a face push or, per axis, a product, a divider
// start and a divider wait for a push along the contact normal; the bit-serial
// root and divider units set the length of those waits. a new request is taken
// while the last result still waits in the output register. no clearing pass:
// rows above the wall count are never read
module circle_wall_pushout (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_z, radius, collide_enable, wall_lo_x, wall_lo_z, wall_hi_x,
  // wall_hi_z, owner
  input  logic [255:0] in_tdata,
  // kind
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_pos_x, new_pos_z, stored_walls, table_full, zero pad
  output logic [79:0]  out_tdata
);
  import cwp_pkg::*;

  state_t state_r, state_nxt;

  // request fields
  kind_t                  kind_r;
  logic signed [Q_W-1:0]  px_r, pz_r;
  logic        [R_W-1:0]  r_r;
  logic                   en_r;
  wall_t                  new_wall_r;
  logic        [Q_W-1:0]  owner_r;
  logic                   full_r;

  // table bookkeeping
  logic [CNT_W-1:0] total_r, idx_r, k_r;

  // per wall datapath
  wall_t                  rd_wall;
  logic signed [Q_W-1:0]  ax0_r, az0_r, ax1_r, az1_r;
  logic                   dx_neg_r, dz_neg_r;
  logic [Q_W-1:0]         dxa_r, dza_r;
  logic [WIDE_W-1:0]      d2_r, prod_r;
  logic [ROOT_W-1:0]      dist_r, pen_r;

  // output register
  logic                   out_valid_r;
  logic signed [Q_W-1:0]  out_x_r, out_z_r;
  logic [STORED_W-1:0]    out_cnt_r;
  logic                   out_full_r;

  // ram
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  wall_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // shared units
  logic [Q_W-1:0]    mul_a, mul_b;
  logic [WIDE_W-1:0] mul_p;
  logic              sq_start, sq_done, dv_start, dv_done;
  logic [ROOT_W-1:0] sq_root;
  logic [WIDE_W-1:0] dv_quo;

  // clamp and distance
  logic signed [Q_W-1:0] cx_lo, cz_lo, cx, cz;
  logic signed [Q_W:0]   dx, dz, dxa, dza;
  logic                  near;

  // face push
  logic signed [Q_W:0]      f_left, f_right, f_back, f_front;
  logic signed [WIDE_W-1:0] q_signed, upd_sum;

  logic in_acc, out_free, scan_end;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign scan_end  = idx_r >= total_r;
  assign rd_wall   = wall_t'(ram_rdata);

  cwp_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WALLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  cwp_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(d2_r),
    .done(sq_done), .root(sq_root)
  );

  cwp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(prod_r),
    .divisor(dist_r), .done(dv_done), .quotient(dv_quo)
  );

  // clamp the centre to the wall just read
  always_comb begin
    cx_lo = (px_r < rd_wall.hi_x) ? px_r : rd_wall.hi_x;
    cx    = (rd_wall.lo_x > cx_lo) ? rd_wall.lo_x : cx_lo;
    cz_lo = (pz_r < rd_wall.hi_z) ? pz_r : rd_wall.hi_z;
    cz    = (rd_wall.lo_z > cz_lo) ? rd_wall.lo_z : cz_lo;
    dx    = 33'(px_r) - 33'(cx);
    dz    = 33'(pz_r) - 33'(cz);
    dxa   = dx[Q_W] ? -dx : dx;
    dza   = dz[Q_W] ? -dz : dz;
    near  = (dxa < $signed({2'b00, r_r})) && (dza < $signed({2'b00, r_r}));
  end

  // one shared 32x32 multiplier, operands picked by step
  always_comb begin
    mul_a = dxa_r;
    mul_b = dxa_r;
    case (state_r)
      S_MDZ:   begin mul_a = dza_r;         mul_b = dza_r;         end
      S_MRR:   begin mul_a = {1'b0, r_r};   mul_b = {1'b0, r_r};   end
      S_MPX:   begin mul_a = dxa_r;         mul_b = pen_r;         end
      S_MPZ:   begin mul_a = dza_r;         mul_b = pen_r;         end
      default: begin mul_a = dxa_r;         mul_b = dxa_r;         end
    endcase
    mul_p = WIDE_W'(mul_a) * WIDE_W'(mul_b);
  end

  // normal push: signed quotient added to the moving coordinate
  always_comb begin
    if (state_r == S_DZW) begin
      q_signed = dz_neg_r ? -$signed(dv_quo) : $signed(dv_quo);
      upd_sum  = WIDE_W'(pz_r) + q_signed;
    end else begin
      q_signed = dx_neg_r ? -$signed(dv_quo) : $signed(dv_quo);
      upd_sum  = WIDE_W'(px_r) + q_signed;
    end
    f_left  = 33'(px_r) - 33'(ax0_r);
    f_right = 33'(ax1_r) - 33'(px_r);
    f_back  = 33'(pz_r) - 33'(az0_r);
    f_front = 33'(az1_r) - 33'(pz_r);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = total_r[ADDR_W-1:0];
    ram_wdata = new_wall_r;
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (kind_t'(in_tuser))
            KIND_ADD:     state_nxt = S_ADD;
            KIND_RESOLVE: state_nxt = in_tdata[95] ? S_RD : S_OUT;
            KIND_REMOVE,
            KIND_CLEAR:   state_nxt = (in_tdata[255:224] != '0) ? S_RD : S_OUT;
            default:      state_nxt = S_OUT;
          endcase
        end
      end
      S_ADD: begin
        ram_we    = (total_r < CNT_W'(MAX_WALLS));
        state_nxt = S_OUT;
      end
      S_RD: begin
        if (scan_end) state_nxt = S_OUT;
        else if (kind_r == KIND_RESOLVE) state_nxt = S_CLAMP;
        else state_nxt = S_RMW;
      end
      S_CLAMP: state_nxt = near ? S_MDX : S_NEXT;
      S_MDX:   state_nxt = S_MDZ;
      S_MDZ:   state_nxt = S_MRR;
      S_MRR:   state_nxt = S_CMP;
      S_CMP:   state_nxt = (d2_r < prod_r) ? S_SQS : S_NEXT;
      S_SQS: begin
        sq_start  = 1'b1;
        state_nxt = S_SQW;
      end
      S_SQW: begin
        if (sq_done) state_nxt = (sq_root > ROOT_W'(DIST_EPS)) ? S_MPX : S_FACE;
      end
      S_MPX: state_nxt = S_DXS;
      S_DXS: begin
        dv_start  = 1'b1;
        state_nxt = S_DXW;
      end
      S_DXW: if (dv_done) state_nxt = S_MPZ;
      S_MPZ: state_nxt = S_DZS;
      S_DZS: begin
        dv_start  = 1'b1;
        state_nxt = S_DZW;
      end
      S_DZW:  if (dv_done) state_nxt = S_NEXT;
      S_FACE: state_nxt = S_NEXT;
      S_NEXT: state_nxt = S_RD;
      S_RMW: begin
        ram_wdata = rd_wall;
        if (kind_r == KIND_REMOVE) begin
          ram_we    = (rd_wall.owner != owner_r);
          ram_waddr = k_r[ADDR_W-1:0];
        end else begin
          ram_we          = (rd_wall.owner == owner_r);
          ram_waddr       = idx_r[ADDR_W-1:0];
          ram_wdata.owner = '0;
        end
        state_nxt = S_RD;
      end
      S_OUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ADD && total_r < CNT_W'(MAX_WALLS)) total_r <= total_r + 1'b1;
      if (state_r == S_RD && scan_end && kind_r == KIND_REMOVE) total_r <= k_r;
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r            <= kind_t'(in_tuser);
      px_r              <= in_tdata[31:0];
      pz_r              <= in_tdata[63:32];
      r_r               <= in_tdata[94:64];
      en_r              <= in_tdata[95];
      new_wall_r.lo_x   <= in_tdata[127:96];
      new_wall_r.lo_z   <= in_tdata[159:128];
      new_wall_r.hi_x   <= in_tdata[191:160];
      new_wall_r.hi_z   <= in_tdata[223:192];
      new_wall_r.owner  <= in_tdata[255:224];
      owner_r           <= in_tdata[255:224];
      full_r            <= 1'b0;
      idx_r             <= '0;
      k_r               <= '0;
    end
    case (state_r)
      S_ADD: full_r <= (total_r >= CNT_W'(MAX_WALLS));
      S_CLAMP: begin
        ax0_r    <= rd_wall.lo_x;
        az0_r    <= rd_wall.lo_z;
        ax1_r    <= rd_wall.hi_x;
        az1_r    <= rd_wall.hi_z;
        dx_neg_r <= dx[Q_W];
        dz_neg_r <= dz[Q_W];
        dxa_r    <= dxa[Q_W-1:0];
        dza_r    <= dza[Q_W-1:0];
      end
      S_MDX: d2_r <= mul_p;
      S_MDZ: prod_r <= mul_p;
      S_MRR: begin
        d2_r   <= d2_r + prod_r;
        prod_r <= mul_p;
      end
      S_SQW: begin
        if (sq_done) begin
          dist_r <= sq_root;
          pen_r  <= ROOT_W'(r_r) - sq_root;
        end
      end
      S_MPX, S_MPZ: prod_r <= mul_p;
      S_DXW: if (dv_done) px_r <= sat32(upd_sum);
      S_DZW: if (dv_done) pz_r <= sat32(upd_sum);
      S_FACE: begin
        // nearest face, ties left, right, back, front
        if (f_left <= f_right && f_left <= f_back && f_left <= f_front)
          px_r <= sat32(WIDE_W'(ax0_r) - WIDE_W'(r_r));
        else if (f_right <= f_back && f_right <= f_front)
          px_r <= sat32(WIDE_W'(ax1_r) + WIDE_W'(r_r));
        else if (f_back <= f_front)
          pz_r <= sat32(WIDE_W'(az0_r) - WIDE_W'(r_r));
        else
          pz_r <= sat32(WIDE_W'(az1_r) + WIDE_W'(r_r));
      end
      S_NEXT: idx_r <= idx_r + 1'b1;
      S_RMW: begin
        idx_r <= idx_r + 1'b1;
        if (kind_r == KIND_REMOVE && rd_wall.owner != owner_r) k_r <= k_r + 1'b1;
      end
      S_OUT: begin
        if (out_free) begin
          out_x_r    <= px_r;
          out_z_r    <= pz_r;
          out_cnt_r  <= STORED_W'(total_r);
          out_full_r <= full_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_full_r, out_cnt_r, out_z_r, out_x_r};

  // checks
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(MAX_WALLS))
    else $error("wall count above table size");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RMW || state_r == S_RD) |-> k_r <= idx_r)
    else $error("compaction write index passed read index");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLAMP) |=> $stable(total_r))
    else $error("wall count changed during resolve");

  a_div_after_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DXW && dv_done) |-> dist_r > ROOT_W'(DIST_EPS))
    else $error("normal push with distance at or below epsilon");

  a_en_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLAMP) |-> (kind_r == KIND_RESOLVE && en_r))
    else $error("wall visit outside an enabled resolve");

endmodule

// ----- tb/tb_circle_wall_pushout.sv -----
// tb_circle_wall_pushout: self-checking testbench for circle_wall_pushout
// drives wall adds, removes, clears and circle resolves and checks each result
// against a behavioral copy of the wall table; depends on cwp_pkg and the rtl
`timescale 1ns / 1ps
module tb_circle_wall_pushout;
  import cwp_pkg::*;

  localparam int  WATCHDOG_LIMIT = 400000;
  localparam int  DRAIN_CYCLES   = 40;
  localparam int  UNIT           = 65536;

  typedef struct {
    kind_t              kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic [30:0]        radius;
    logic               en;
    logic signed [31:0] lo_x;
    logic signed [31:0] lo_z;
    logic signed [31:0] hi_x;
    logic signed [31:0] hi_z;
    logic [31:0]        owner;
  } request_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] z;
    logic [8:0]         walls;
    logic               full;
  } outcome_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [79:0]  out_tdata;

  circle_wall_pushout u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // shadow copy of the wall table
  logic signed [31:0] tbl_lo_x [MAX_WALLS];
  logic signed [31:0] tbl_lo_z [MAX_WALLS];
  logic signed [31:0] tbl_hi_x [MAX_WALLS];
  logic signed [31:0] tbl_hi_z [MAX_WALLS];
  logic [31:0]        tbl_owner[MAX_WALLS];
  int                 tbl_count;

  outcome_t pending_outcomes[$];
  int       mismatches;
  int       idle_cycles;
  bit       sender_gaps;
  int       burst_left;

  // clock and receiver stall pattern
  initial clk = 1'b0;
  always #10 clk = ~clk;

  int stall_mode;
  int stall_cycle;
  always @(negedge clk) begin
    stall_cycle++;
    if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ((stall_cycle / 5) % 2 == 0);
    endcase
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint clip_q(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // push the circle out of one stored wall
  function automatic void push_from_wall(input int w, inout longint px, inout longint pz,
                                         input longint r);
    longint ax0, az0, ax1, az1, cx, cz, dx, dz, pen, span;
    longint lft, rgt, bck, frt, m;
    longint unsigned d2, rr;
    ax0 = tbl_lo_x[w];
    az0 = tbl_lo_z[w];
    ax1 = tbl_hi_x[w];
    az1 = tbl_hi_z[w];
    cx = (px < ax1) ? px : ax1;
    cx = (cx > ax0) ? cx : ax0;
    cz = (pz < az1) ? pz : az1;
    cz = (cz > az0) ? cz : az0;
    dx = px - cx;
    dz = pz - cz;
    if ((dx < 0 ? -dx : dx) >= r || (dz < 0 ? -dz : dz) >= r) return;
    d2 = longint'(dx * dx) + longint'(dz * dz);
    rr = r * r;
    if (d2 >= rr) return;
    span = longint'(root_floor(d2));
    if (span > DIST_EPS) begin
      pen = r - span;
      px = clip_q(px + (dx * pen) / span);
      pz = clip_q(pz + (dz * pen) / span);
    end else begin
      // centre inside or within DIST_EPS: nearest face wins, ties go left, right, back, front
      lft = px - ax0;
      rgt = ax1 - px;
      bck = pz - az0;
      frt = az1 - pz;
      m = lft;
      if (rgt < m) m = rgt;
      if (bck < m) m = bck;
      if (frt < m) m = frt;
      if (m == lft) px = clip_q(ax0 - r);
      else if (m == rgt) px = clip_q(ax1 + r);
      else if (m == bck) pz = clip_q(az0 - r);
      else pz = clip_q(az1 + r);
    end
  endfunction

  // apply one request to the shadow table and return what the block must report
  function automatic outcome_t predict_outcome(input request_t rq);
    outcome_t o;
    longint px, pz;
    int k;
    px = rq.pos_x;
    pz = rq.pos_z;
    o.full = 1'b0;
    case (rq.kind)
      KIND_ADD: begin
        if (tbl_count >= MAX_WALLS) begin
          o.full = 1'b1;
        end else begin
          tbl_lo_x[tbl_count]  = rq.lo_x;
          tbl_lo_z[tbl_count]  = rq.lo_z;
          tbl_hi_x[tbl_count]  = rq.hi_x;
          tbl_hi_z[tbl_count]  = rq.hi_z;
          tbl_owner[tbl_count] = rq.owner;
          tbl_count++;
        end
      end
      KIND_RESOLVE: begin
        if (rq.en)
          for (int i = 0; i < tbl_count; i++) push_from_wall(i, px, pz, longint'(rq.radius));
      end
      KIND_REMOVE: begin
        if (rq.owner != 0) begin
          k = 0;
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_owner[i] != rq.owner) begin
              tbl_lo_x[k]  = tbl_lo_x[i];
              tbl_lo_z[k]  = tbl_lo_z[i];
              tbl_hi_x[k]  = tbl_hi_x[i];
              tbl_hi_z[k]  = tbl_hi_z[i];
              tbl_owner[k] = tbl_owner[i];
              k++;
            end
          end
          tbl_count = k;
        end
      end
      default: begin
        if (rq.owner != 0)
          for (int i = 0; i < tbl_count; i++)
            if (tbl_owner[i] == rq.owner) tbl_owner[i] = '0;
      end
    endcase
    o.x = px[31:0];
    o.z = pz[31:0];
    o.walls = tbl_count[8:0];
    return o;
  endfunction

  // ------------------------------------------------------------------ sender
  task automatic send_request(input request_t rq);
    if (sender_gaps && burst_left <= 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_tdata = {rq.owner, rq.hi_z, rq.hi_x, rq.lo_z, rq.lo_x, rq.en, rq.radius,
                rq.pos_z, rq.pos_x};
    in_tuser = rq.kind;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_outcomes = {pending_outcomes, predict_outcome(rq)};
    burst_left--;
    @(negedge clk);
  endtask

  function automatic request_t blank_request(input kind_t k);
    request_t rq;
    rq.kind = k;
    rq.pos_x = '0; rq.pos_z = '0; rq.radius = '0; rq.en = 1'b1;
    rq.lo_x = '0; rq.lo_z = '0; rq.hi_x = '0; rq.hi_z = '0; rq.owner = '0;
    return rq;
  endfunction

  task automatic add_wall(input int lx, input int lz, input int hx, input int hz,
                          input logic [31:0] own);
    request_t rq;
    rq = blank_request(KIND_ADD);
    rq.lo_x = lx; rq.lo_z = lz; rq.hi_x = hx; rq.hi_z = hz; rq.owner = own;
    send_request(rq);
  endtask

  task automatic resolve_circle(input int px, input int pz, input int r,
                                input logic en);
    request_t rq;
    rq = blank_request(KIND_RESOLVE);
    rq.pos_x = px; rq.pos_z = pz; rq.radius = 31'(r); rq.en = en;
    send_request(rq);
  endtask

  task automatic owner_op(input kind_t k, input logic [31:0] own);
    request_t rq;
    rq = blank_request(k);
    rq.owner = own;
    rq.pos_x = $urandom;
    rq.pos_z = $urandom;
    send_request(rq);
  endtask

  // ------------------------------------------------------------------ checker
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_circle_wall_pushout: errors");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_tdata[31:0] !== want.x || out_tdata[63:32] !== want.z ||
            out_tdata[72:64] !== want.walls || out_tdata[73] !== want.full) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want x %h z %h walls %0d full %b, got x %h z %h walls %0d full %b",
                     want.x, want.z, want.walls, want.full, out_tdata[31:0],
                     out_tdata[63:32], out_tdata[72:64], out_tdata[73]);
        end
      end
    end
  end

  // ------------------------------------------------------------------ tests
  // clean normal push, zero radius, disabled collision and field extremes
  task automatic test_basic_push();
    add_wall(0, 0, 10 * UNIT, 10 * UNIT, 1);
    resolve_circle(12 * UNIT, 5 * UNIT, 3 * UNIT, 1'b1);
    resolve_circle(-UNIT, -UNIT, 2 * UNIT, 1'b1);
    resolve_circle(12 * UNIT, 5 * UNIT, 3 * UNIT, 1'b0);
    resolve_circle(5 * UNIT, 5 * UNIT, 0, 1'b1);
    resolve_circle(32'h7fffffff, 32'h80000000, 31'h7fffffff, 1'b1);
    resolve_circle(32'h80000000, 32'h7fffffff, 31'h7fffffff, 1'b0);
  endtask

  // centre inside: each face, the tie order and saturation
  task automatic test_face_push();
    resolve_circle(UNIT, 5 * UNIT, 2 * UNIT, 1'b1);
    resolve_circle(9 * UNIT, 5 * UNIT, 2 * UNIT, 1'b1);
    resolve_circle(5 * UNIT, UNIT, 2 * UNIT, 1'b1);
    resolve_circle(5 * UNIT, 9 * UNIT, 2 * UNIT, 1'b1);
    resolve_circle(5 * UNIT, 5 * UNIT, 2 * UNIT, 1'b1);
    resolve_circle(10 * UNIT, 5 * UNIT, UNIT, 1'b1);
    owner_op(KIND_REMOVE, 1);
    add_wall(32'h7ff00000, 0, 32'h7fffffff, 10 * UNIT, 2);
    resolve_circle(32'h7ffffff0, 5 * UNIT, 31'h40000000, 1'b1);
    add_wall(10 * UNIT, 10 * UNIT, 0, 0, 3);  // inverted bounds
    resolve_circle(11 * UNIT, 11 * UNIT, 2 * UNIT, 1'b1);
    resolve_circle(-UNIT, 5 * UNIT, 2 * UNIT, 1'b1);
  endtask

  // owner zero is ignored, removal keeps the order of the rest, clear unmarks
  task automatic test_owner_ops();
    add_wall(20 * UNIT, 0, 22 * UNIT, 2 * UNIT, 0);
    add_wall(30 * UNIT, 0, 32 * UNIT, 2 * UNIT, 5);
    add_wall(40 * UNIT, 0, 42 * UNIT, 2 * UNIT, 6);
    owner_op(KIND_REMOVE, 0);
    owner_op(KIND_CLEAR, 0);
    owner_op(KIND_CLEAR, 5);
    owner_op(KIND_REMOVE, 5);
    owner_op(KIND_REMOVE, 2);
    resolve_circle(29 * UNIT, UNIT, 2 * UNIT, 1'b1);
    owner_op(KIND_REMOVE, 32'hffffffff);
  endtask

  function automatic int near_coord(input int span);
    return int'($urandom_range(0, 2 * span * UNIT)) - span * UNIT;
  endfunction

  // mostly walls and circles in one small region, with wild items mixed in
  task automatic test_random_traffic();
    request_t rq;
    int pick, a, b;
    for (int n = 0; n < 70; n++) begin
      pick = $urandom_range(0, 99);
      rq = blank_request(KIND_RESOLVE);
      rq.owner = $urandom_range(0, 4);
      if (pick < 30 && tbl_count < 40) begin
        rq.kind = KIND_ADD;
        a = near_coord(40);
        b = near_coord(40);
        rq.lo_x = a; rq.lo_z = b;
        rq.hi_x = a + int'($urandom_range(0, 8 * UNIT));
        rq.hi_z = b + int'($urandom_range(0, 8 * UNIT));
      end else if (pick < 70) begin
        rq.pos_x = near_coord(45);
        rq.pos_z = near_coord(45);
        rq.radius = 31'($urandom_range(0, 6 * UNIT));
        rq.en = ($urandom_range(0, 9) != 0);
      end else if (pick < 80 || tbl_count >= 40) begin
        rq.kind = KIND_REMOVE;
      end else if (pick < 87) begin
        rq.kind = KIND_CLEAR;
      end else begin
        rq.kind = kind_t'($urandom_range(0, 3));
        rq.pos_x = $urandom; rq.pos_z = $urandom;
        rq.radius = 31'($urandom); rq.en = 1'($urandom);
        rq.lo_x = $urandom; rq.lo_z = $urandom;
        rq.hi_x = $urandom; rq.hi_z = $urandom;
        rq.owner = $urandom;
        if (rq.kind == KIND_ADD && tbl_count >= 40) rq.kind = KIND_CLEAR;
      end
      if (n == 35) sender_gaps = 1'b0;
      if (n == 50) sender_gaps = 1'b1;
      send_request(rq);
    end
  endtask

  // ------------------------------------------------------------------ main
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b1;
    stall_mode = 0;
    stall_cycle = 0;
    tbl_count = 0;
    mismatches = 0;
    idle_cycles = 0;
    sender_gaps = 1'b1;
    burst_left = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_basic_push();
    test_face_push();
    test_owner_ops();
    test_random_traffic();
    in_tvalid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_circle_wall_pushout: clean");
    end else begin
      $display("tb_circle_wall_pushout: errors");
    end
    $finish;
  end
endmodule
